// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/rdwf_pkg.sv
package rdwf_pkg;

    localparam int Window   = 8192;
    localparam int SlotBits = $clog2(Window);
    localparam int HeldBits = $clog2(Window + 1);
    localparam int KeyBits  = 64;

    localparam logic [HeldBits-1:0] WindowLen = HeldBits'(Window);

    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_FOREIGN   = 2'd1,
        VERDICT_DUPLICATE = 2'd2,
        VERDICT_MALFORMED = 2'd3
    } t_verdict;

    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan_step;
        logic append;
    } t_cmd;

    typedef struct packed {
        logic foreign;
        logic malformed;
        logic held_zero;
        logic match;
        logic scan_end;
    } t_sts;

endpackage

// File: hdl/rtp_duplicate_window_filter_unit.sv
// RTP duplicate window filter.
// Input channel (i_valid/o_ready) takes one parsed RTP header word with its
// sender address; output channel (o_valid/i_ready) returns one 2-bit verdict
// word per header: accept, foreign source, duplicate, or malformed.
// Config over APB: addr 0 source filter enable, addr 4 expected source addr.
// Write config only while no header is in flight.
// Foreign or malformed headers go from the check straight to o_valid, and an
// empty window goes straight to the append; otherwise the held keys are
// scanned one per cycle from the key RAM, oldest first. A duplicate stops
// the scan at its hit.
// One header is processed at a time; o_ready returns the cycle after the
// verdict word is taken.
// Reset empties the window (held count and oldest pointer cleared) and
// clears config; RAM contents need no clearing.
// A stalled receiver holds the verdict word and keeps o_ready low.
module rtp_duplicate_window_filter_unit
    import rdwf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_parse_ok,
    input  logic [31:0] i_source_addr,
    input  logic [31:0] i_sync_source,
    input  logic [31:0] i_media_time,
    input  logic [15:0] i_sequence_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_verdict,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd     cmd;
    t_sts     sts;
    t_verdict verdict;
    logic        r_filter_en;
    logic [31:0] r_expected_addr;

    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? r_expected_addr : {31'd0, r_filter_en};
    assign o_verdict = verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en     <= 1'b0;
            r_expected_addr <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_expected_addr <= pwdata;
            else          r_filter_en     <= pwdata[0];
        end
    end

    rdwf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_verdict (verdict),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    rdwf_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_filter_en     (r_filter_en),
        .i_expected_addr (r_expected_addr),
        .i_parse_ok      (i_parse_ok),
        .i_source_addr   (i_source_addr),
        .i_sync_source   (i_sync_source),
        .i_media_time    (i_media_time),
        .i_sequence_req  (i_sequence_req)
    );

endmodule

// File: hdl/rdwf_ctrl.sv
module rdwf_ctrl
    import rdwf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    output t_verdict o_verdict,
    output t_cmd     o_cmd,
    input  t_sts     i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_APPEND,
        ST_OUT
    } t_state;

    t_state   r_state;
    t_verdict r_verdict;

    assign o_ready   = (r_state == ST_IDLE);
    assign o_valid   = (r_state == ST_OUT);
    assign o_verdict = r_verdict;

    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = (r_state == ST_IDLE) && i_valid;
        o_cmd.scan_start = (r_state == ST_CHECK) && !i_sts.foreign && !i_sts.malformed
                           && !i_sts.held_zero;
        o_cmd.scan_step  = (r_state == ST_SCAN) && !i_sts.match && !i_sts.scan_end;
        o_cmd.append     = (r_state == ST_APPEND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_verdict <= VERDICT_ACCEPT;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    priority if (i_sts.foreign) begin
                        r_verdict <= VERDICT_FOREIGN;
                        r_state   <= ST_OUT;
                    end else if (i_sts.malformed) begin
                        r_verdict <= VERDICT_MALFORMED;
                        r_state   <= ST_OUT;
                    end else if (i_sts.held_zero) begin
                        r_state   <= ST_APPEND;
                    end else begin
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    priority if (i_sts.match) begin
                        r_verdict <= VERDICT_DUPLICATE;
                        r_state   <= ST_OUT;
                    end else if (i_sts.scan_end) begin
                        r_state   <= ST_APPEND;
                    end
                end
                ST_APPEND: begin
                    r_verdict <= VERDICT_ACCEPT;
                    r_state   <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/rdwf_dpath.sv
module rdwf_dpath
    import rdwf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_filter_en,
    input  logic [31:0] i_expected_addr,
    input  logic        i_parse_ok,
    input  logic [31:0] i_source_addr,
    input  logic [31:0] i_sync_source,
    input  logic [31:0] i_media_time,
    input  logic [15:0] i_sequence_req
);

    `include "assert_macros.svh"

    logic [KeyBits-1:0]  mem [Window];
    logic [KeyBits-1:0]  r_key;
    logic [KeyBits-1:0]  r_rdata;
    logic                r_foreign;
    logic                r_malformed;
    logic [SlotBits-1:0] r_oldest;
    logic [HeldBits-1:0] r_held;
    logic [HeldBits-1:0] r_idx;
    logic                r_rd_vld;
    logic [SlotBits-1:0] rd_addr;
    logic [SlotBits-1:0] wr_addr;
    logic [KeyBits-1:0]  n_key;

    assign n_key = {i_sync_source, 32'd0}
                 ^ {31'd0, i_media_time, 1'b0}
                 ^ {48'd0, i_sequence_req};

    assign rd_addr = r_oldest + r_idx[SlotBits-1:0];
    assign wr_addr = r_oldest + r_held[SlotBits-1:0];

    assign o_sts.foreign   = r_foreign;
    assign o_sts.malformed = r_malformed;
    assign o_sts.held_zero = (r_held == '0);
    assign o_sts.match     = r_rd_vld && (r_rdata == r_key);
    assign o_sts.scan_end  = (r_idx == r_held) && !r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key       <= n_key;
            r_foreign   <= i_filter_en && (i_source_addr != i_expected_addr);
            r_malformed <= !i_parse_ok;
        end
        if (i_cmd.append) mem[wr_addr] <= r_key;
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_held   <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_idx != r_held) begin
                    r_idx    <= r_idx + 1'b1;
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end
            if (i_cmd.append) begin
                if (r_held == WindowLen) r_oldest <= r_oldest + 1'b1;
                else                     r_held   <= r_held + 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_held_max, i_clk, i_rst_n, r_held <= WindowLen, "window overfilled")
    `ASSERT_IMPLIES(a_oldest_fill, i_clk, i_rst_n, r_held != WindowLen, r_oldest == '0,
        "oldest slot moved before window full")
    `ASSERT_IMPLIES(a_no_dup_append, i_clk, i_rst_n, i_cmd.append, !o_sts.match,
        "append during duplicate hit")

endmodule
